// File: hw/rtl/xrgb_pkg.sv
// Package for the xyY to RGB converter: data widths, pipeline depths and
// the signed Q4.16 XYZ-to-RGB matrix folded into per-row constants.
// No dependencies.
package xrgb_pkg;

    localparam int IN_W   = 16;               // width of every input field
    localparam int CH_W   = 16;               // width of every colour channel
    localparam int S_W    = 36;               // signed weighted chromaticity sum
    localparam int NUM_W  = S_W + IN_W;       // signed luminance times sum
    localparam int REM_W  = NUM_W + 1;        // unsigned dividend and remainder
    localparam int NUM_LAT = 3;               // stages in the numerator pipeline
    localparam int DIV_LAT = CH_W + 1;        // rounding set-up plus one stage per bit
    localparam int CORE_LAT = NUM_LAT + DIV_LAT;

    typedef logic signed [S_W-1:0]   sum_t;
    typedef logic signed [NUM_W-1:0] num_t;
    typedef logic [REM_W-1:0]        rem_t;
    typedef logic [CH_W-1:0]         chan_t;

    // Row k of the matrix is (a, b, c). With z = 65536 - x - y the sum
    // a*x + b*y + c*z becomes (a-c)*x + (b-c)*y + c*65536.
    localparam logic signed [S_W-1:0] COEF_X [3] = '{
        36'sd194257, -36'sd69856, -36'sd72228
    };
    localparam logic signed [S_W-1:0] COEF_Y [3] = '{
        -36'sd50363, 36'sd126775, -36'sd93628
    };
    localparam logic signed [S_W-1:0] COEF_K [3] = '{
        -36'sd1711603712, 36'sd188219392, 36'sd5054332928
    };

endpackage

// File: hw/rtl/xrgb_numer.sv
// Numerator pipeline for one colour channel: luminance times the weighted
// chromaticity sum of one matrix row. Depends on xrgb_pkg.
module xrgb_numer
    import xrgb_pkg::*;
#(
    parameter int ROW = 0
)
(
    input  logic              clk,
    input  logic [IN_W-1:0]   chrom_x,
    input  logic [IN_W-1:0]   chrom_y,
    input  logic [IN_W-1:0]   luminance,
    output num_t              num
);

    sum_t            px_reg;
    sum_t            py_reg;
    logic [IN_W-1:0] lum1_reg;
    sum_t            s_reg;
    logic [IN_W-1:0] lum2_reg;
    num_t            num_reg;

    sum_t px_next;
    sum_t py_next;
    sum_t s_next;
    num_t num_next;

    always_comb
    begin
        px_next  = S_W'(COEF_X[ROW] * $signed({{(S_W-IN_W){1'b0}}, chrom_x}));
        py_next  = S_W'(COEF_Y[ROW] * $signed({{(S_W-IN_W){1'b0}}, chrom_y}));
        s_next   = px_reg + py_reg + COEF_K[ROW];
        num_next = NUM_W'($signed({1'b0, lum2_reg}) * s_reg);
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        lum1_reg <= luminance;
        s_reg    <= s_next;
        lum2_reg <= lum1_reg;
        num_reg  <= num_next;
    end

    assign num = num_reg;

endmodule

// File: hw/rtl/xrgb_divider.sv
// Pipelined restoring divider for one channel: rounds num / (y * 65536)
// half up, clamps non-positive values and saturates. Depends on xrgb_pkg.
module xrgb_divider
    import xrgb_pkg::*;
(
    input  logic            clk,
    input  num_t            num,
    input  logic [IN_W-1:0] chrom_y,
    output chan_t           chan
);

    rem_t            rem_reg [0:CH_W];
    chan_t           q_reg   [0:CH_W];
    logic [IN_W-1:0] y_reg   [0:CH_W];
    logic            pos_reg [0:CH_W];
    logic            sat_reg [0:CH_W];

    rem_t rem_next;
    logic sat_next;

    // Adding half the divisor gives round half up; a dividend at or above
    // 65536 times the divisor cannot fit the channel and saturates.
    always_comb
    begin
        rem_next = REM_W'($unsigned(num)) + (REM_W'(chrom_y) << (CH_W - 1));
        sat_next = rem_next >= (REM_W'(chrom_y) << (2 * CH_W));
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= rem_next;
        q_reg[0]   <= '0;
        y_reg[0]   <= chrom_y;
        pos_reg[0] <= num > 0;
        sat_reg[0] <= sat_next;
    end

    for (genvar i = 1; i <= CH_W; i++)
    begin : g_step
        localparam int SH = CH_W + (CH_W - i);
        rem_t dsh;
        logic ge;

        always_comb
        begin
            dsh = REM_W'(y_reg[i-1]) << SH;
            ge  = rem_reg[i-1] >= dsh;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= ge ? rem_reg[i-1] - dsh : rem_reg[i-1];
            q_reg[i]   <= {q_reg[i-1][CH_W-2:0], ge};
            y_reg[i]   <= y_reg[i-1];
            pos_reg[i] <= pos_reg[i-1];
            sat_reg[i] <= sat_reg[i-1];
        end
    end

    always_comb
    begin
        if (!pos_reg[CH_W])
            chan = '0;
        else if (sat_reg[CH_W])
            chan = '1;
        else
            chan = q_reg[CH_W];
    end

endmodule

// File: hw/rtl/xyy_to_rgb_convert_core.sv
// Top level of the CIE xyY to linear RGB converter: three channel numerator
// pipelines and three pipelined dividers. Depends on xrgb_pkg, xrgb_numer, xrgb_divider.
//
// The converter takes one colour word in every clock cycle: busy is never
// raised, so a word is taken at every edge where start is high. Each word
// gives exactly one result word, shown for one cycle with done high; the
// receiver cannot hold it off, and none is needed since the pipeline never
// stalls. The pipeline is made of three numerator stages, one rounding
// set-up stage, sixteen restoring divider stages (one quotient bit each,
// the dominant part) and the output register. A colour with zero chromaticity
// y yields div_by_zero high and all channels zero. Channels are Q2.14,
// clamped at zero and saturated at the top code.
module xyy_to_rgb_convert_core
    import xrgb_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [IN_W-1:0] chrom_x,
    input  logic [IN_W-1:0] chrom_y,
    input  logic [IN_W-1:0] luminance,
    output logic            done,
    output logic [CH_W-1:0] red,
    output logic [CH_W-1:0] green,
    output logic [CH_W-1:0] blue,
    output logic            div_by_zero
);

    // Chromaticity y follows the numerator stages to meet the dividers.
    logic [IN_W-1:0] y_dly_reg [0:NUM_LAT-1];
    // Valid and zero-y flags travel alongside the data through every stage.
    logic            vld_reg   [0:CORE_LAT-1];
    logic            dz_reg    [0:CORE_LAT-1];

    num_t  num   [3];
    chan_t chan  [3];

    logic  done_reg;
    logic  dz_out_reg;
    chan_t red_reg;
    chan_t green_reg;
    chan_t blue_reg;

    for (genvar k = 0; k < 3; k++)
    begin : g_chan
        xrgb_numer #(.ROW(k)) u_numer
        (
            .clk       (clk),
            .chrom_x   (chrom_x),
            .chrom_y   (chrom_y),
            .luminance (luminance),
            .num       (num[k])
        );

        xrgb_divider u_div
        (
            .clk     (clk),
            .num     (num[k]),
            .chrom_y (y_dly_reg[NUM_LAT-1]),
            .chan    (chan[k])
        );
    end

    always_ff @(posedge clk)
    begin
        y_dly_reg[0] <= chrom_y;
        for (int i = 1; i < NUM_LAT; i++)
        begin
            y_dly_reg[i] <= y_dly_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CORE_LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start;
            for (int i = 1; i < CORE_LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            done_reg <= vld_reg[CORE_LAT-1];
        end
    end

    // Output word: a zero y overrides whatever the divider made of it.
    always_ff @(posedge clk)
    begin
        dz_reg[0] <= chrom_y == '0;
        for (int i = 1; i < CORE_LAT; i++)
        begin
            dz_reg[i] <= dz_reg[i-1];
        end
        dz_out_reg <= dz_reg[CORE_LAT-1];
        red_reg    <= dz_reg[CORE_LAT-1] ? '0 : chan[0];
        green_reg  <= dz_reg[CORE_LAT-1] ? '0 : chan[1];
        blue_reg   <= dz_reg[CORE_LAT-1] ? '0 : chan[2];
    end

    assign busy        = 1'b0;
    assign done        = done_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign div_by_zero = dz_out_reg;

endmodule

// File: hw/rtl/xrgb_checker.sv
// Port-level checks for the xyY to RGB converter, bound to the top level.
// Depends on xrgb_pkg and xyy_to_rgb_convert_core.
module xrgb_checker
    import xrgb_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic [IN_W-1:0] chrom_y,
    input logic            done,
    input logic [CH_W-1:0] red,
    input logic [CH_W-1:0] green,
    input logic [CH_W-1:0] blue,
    input logic            div_by_zero
);

    localparam int LAT = CORE_LAT + 1;

    // Every accepted word comes back as a result with done high.
    a_word_returns: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(start && !busy, LAT) && $past(rst_n, LAT)) |-> done)
        else $error("accepted word produced no result");

    // No result appears without an accepted word behind it.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without accepted word");

    // A zero y is flagged on its own result.
    a_zero_y_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(chrom_y, LAT) == '0) |-> div_by_zero)
        else $error("zero y not flagged");

    // A flagged result carries black.
    a_zero_y_black: assert property (@(posedge clk) disable iff (!rst_n)
        (done && div_by_zero) |-> (red == '0 && green == '0 && blue == '0))
        else $error("flagged result is not black");

endmodule

bind xyy_to_rgb_convert_core xrgb_checker u_xrgb_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .chrom_y     (chrom_y),
    .done        (done),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .div_by_zero (div_by_zero)
);

// File: tb/xyy_to_rgb_convert_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the xyY to RGB converter core: directed corner
// colours followed by random ones, each result checked against a predictor.
// Depends on xrgb_pkg and the xyy_to_rgb_convert_core RTL.
module xyy_to_rgb_convert_core_tb;
    import xrgb_pkg::*;

    // Depth of the core pipeline with its output register; the final wait adds a margin.
    localparam int PIPE_DEPTH  = 21;
    localparam int STALL_LIMIT = 2000;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    logic [IN_W-1:0] chrom_x;
    logic [IN_W-1:0] chrom_y;
    logic [IN_W-1:0] luminance;
    logic            done;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            div_by_zero;

    // One predicted result word.
    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        logic            dz;
    } rgb_word_t;

    rgb_word_t pending_rgb[$];
    int        error_count;
    int        words_sent;
    int        words_seen;
    int        dz_seen;
    int        sat_seen;
    int        idle_cycles;

    // The Q4.16 matrix, one row per channel, applied to x, y and z = 1 - x - y.
    longint rgb_matrix [3][3] = '{
        '{168140, -76480, -26117},
        '{-66984, 129647,   2872},
        '{  4895, -16505,  77123}
    };

    xyy_to_rgb_convert_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .chrom_x     (chrom_x),
        .chrom_y     (chrom_y),
        .luminance   (luminance),
        .done        (done),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .div_by_zero (div_by_zero)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // One channel: luminance times the weighted sum over y, rounded half up
    // once at the end, then clamped at zero and saturated at the top code.
    function automatic logic [CH_W-1:0] channel_code(int row, longint x, longint y,
                                                     longint lum);
        longint s;
        longint num;
        longint den;
        longint q;
        s = rgb_matrix[row][0] * x + rgb_matrix[row][1] * y
            + rgb_matrix[row][2] * (65536 - x - y);
        num = lum * s;
        den = y * 65536;
        if (num <= 0)
            return '0;
        q = (num + den / 2) / den;
        if (q > 65535)
            return '1;
        return q[CH_W-1:0];
    endfunction

    function automatic rgb_word_t predict_rgb(logic [IN_W-1:0] x, logic [IN_W-1:0] y,
                                              logic [IN_W-1:0] lum);
        rgb_word_t w;
        w = '0;
        if (y == 0)
            w.dz = 1'b1;
        else
        begin
            w.r = channel_code(0, x, y, lum);
            w.g = channel_code(1, x, y, lum);
            w.b = channel_code(2, x, y, lum);
        end
        return w;
    endfunction

    // Mostly short gaps, now and then a long one; never empty, so start is
    // not lowered and raised again at the same edge.
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
        repeat (n) @(posedge clk);
    endtask

    // Offers one colour word and holds it until the core takes it. Start is
    // left high between back-to-back words, so it is only lowered when a gap
    // follows.
    task automatic send_colour(logic [IN_W-1:0] x, logic [IN_W-1:0] y,
                               logic [IN_W-1:0] lum, bit allow_gap = 1);
        start     <= 1'b1;
        chrom_x   <= x;
        chrom_y   <= y;
        luminance <= lum;
        do
            @(posedge clk);
        while (busy);
        pending_rgb.push_back(predict_rgb(x, y, lum));
        words_sent++;
        if (allow_gap && $urandom_range(0, 2) == 0)
        begin
            start <= 1'b0;
            idle_gap();
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_rgb.size() != 0)
            @(posedge clk);
    endtask

    // Corners of every field, zero y, x + y above one, saturation.
    task automatic test_directed();
        send_colour(16'd0, 16'd0, 16'd0);
        send_colour(16'hFFFF, 16'd0, 16'hFFFF);
        send_colour(16'd21843, 16'd21843, 16'd16384);
        send_colour(16'd41943, 16'd21627, 16'd16384);
        send_colour(16'd19005, 16'd39322, 16'd16384);
        send_colour(16'd9830, 16'd3932, 16'd16384);
        send_colour(16'd0, 16'd1, 16'hFFFF);
        send_colour(16'hFFFF, 16'd1, 16'hFFFF);
        send_colour(16'd0, 16'hFFFF, 16'hFFFF);
        send_colour(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_colour(16'hFFFF, 16'hFFFF, 16'd0);
        send_colour(16'd40000, 16'd40000, 16'd30000);
        send_colour(16'd1, 16'd1, 16'd1);
        send_colour(16'hAAAA, 16'h5555, 16'h5555);
        send_colour(16'h5555, 16'hAAAA, 16'hAAAA);
        send_colour(16'd30000, 16'd0, 16'd12345);
    endtask

    // Stops sending until the pipeline has emptied, then carries on.
    task automatic test_full_drain();
        repeat (12)
            send_colour(IN_W'($urandom), IN_W'($urandom_range(1, 65535)),
                        IN_W'($urandom), 0);
        wait_drained();
        repeat (4)
            send_colour(IN_W'($urandom), IN_W'($urandom_range(1, 65535)),
                        IN_W'($urandom), 0);
    endtask

    // Random colours, mostly inside the gamut, some anywhere at all.
    task automatic test_random();
        logic [IN_W-1:0] x;
        logic [IN_W-1:0] y;
        repeat (420)
        begin
            case ($urandom_range(0, 9))
                0: y = 16'd0;
                1: y = IN_W'($urandom_range(1, 64));
                default: y = IN_W'($urandom_range(1, 65535));
            endcase
            if ($urandom_range(0, 3) != 0 && y != 0)
                x = IN_W'($urandom_range(0, 65535 - y));
            else
                x = IN_W'($urandom);
            send_colour(x, y, IN_W'($urandom), $urandom_range(0, 3) != 0);
        end
    endtask

    // Every word with done high is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_rgb.size() == 0)
            begin
                $error("result word with no colour outstanding");
                error_count++;
            end
            else
            begin
                rgb_word_t want;
                want = pending_rgb.pop_front();
                words_seen++;
                if (div_by_zero)
                    dz_seen++;
                if (red == '1 || green == '1 || blue == '1)
                    sat_seen++;
                if (red !== want.r)
                begin
                    $error("red: expected %0d, got %0d", want.r, red);
                    error_count++;
                end
                if (green !== want.g)
                begin
                    $error("green: expected %0d, got %0d", want.g, green);
                    error_count++;
                end
                if (blue !== want.b)
                begin
                    $error("blue: expected %0d, got %0d", want.b, blue);
                    error_count++;
                end
                if (div_by_zero !== want.dz)
                begin
                    $error("div_by_zero: expected %0d, got %0d", want.dz, div_by_zero);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which no word moves either way.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        chrom_x     = '0;
        chrom_y     = '0;
        luminance   = '0;
        error_count = 0;
        words_sent  = 0;
        words_seen  = 0;
        dz_seen     = 0;
        sat_seen    = 0;
        idle_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_drain();
        test_random();

        wait_drained();
        repeat (PIPE_DEPTH + 5) @(posedge clk);
        if (pending_rgb.size() != 0)
        begin
            $error("%0d predicted words never arrived", pending_rgb.size());
            error_count++;
        end

        $display("Sent %0d colour words, checked %0d results (%0d zero y, %0d saturated).",
                 words_sent, words_seen, dz_seen, sat_seen);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
